>>> rtl/xlfv_pkg.sv
`timescale 1ns / 1ps
// types, constants and parse functions for the xsd lexical form validator
// no dependencies

package xlfv_pkg;

    localparam int NWORDS = 9;

    typedef logic [2:0] t_form;

    localparam t_form FORM_BOOL = 3'd0;
    localparam t_form FORM_INT  = 3'd1;
    localparam t_form FORM_DEC  = 3'd2;
    localparam t_form FORM_DBL  = 3'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_BEGIN    = 4'd1,
        PH_SIGN     = 4'd2,
        PH_INT      = 4'd3,
        PH_DOT      = 4'd4,
        PH_DOTNODIG = 4'd5,
        PH_FRAC     = 4'd6,
        PH_EXPE     = 4'd7,
        PH_EXPSIGN  = 4'd8,
        PH_EXPDIG   = 4'd9
    } t_phase;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LE    = 8'h65;

    localparam logic [NWORDS-1:0] ALL_WORDS     = 9'h1FF;
    localparam logic [NWORDS-1:0] BOOL_WORDS    = 9'h03F;
    localparam logic [NWORDS-1:0] TRUE_WORDS    = 9'h007;
    localparam logic [NWORDS-1:0] SPECIAL_WORDS = 9'h1C0;

    // words left-justified, eight characters each
    localparam logic [63:0] WORD_TEXT [NWORDS] = '{
        {"true",  32'h0},
        {"TRUE",  32'h0},
        {"1",     56'h0},
        {"false", 24'h0},
        {"FALSE", 24'h0},
        {"0",     56'h0},
        {"-INF",  32'h0},
        {"INF",   40'h0},
        {"NaN",   40'h0}
    };

    localparam logic [2:0] WORD_LEN [NWORDS] = '{
        3'd4, 3'd4, 3'd1, 3'd5, 3'd5, 3'd1, 3'd4, 3'd3, 3'd3
    };

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_byte;
        logic       has_char;
        logic       last;
    } t_item;

    typedef struct packed {
        logic valid_res;
        logic bool_value;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == CH_LE) || (c == CH_UE);
    endfunction

    // PH_IDLE on return means the character is rejected
    function automatic t_phase next_phase(input t_form form, input t_phase ph,
                                          input logic [7:0] c);
        t_phase np;
        np = PH_IDLE;
        if (form == FORM_INT) begin
            if (ph == PH_BEGIN && is_sign(c)) begin
                np = PH_SIGN;
            end else if (ph inside {PH_BEGIN, PH_SIGN, PH_INT} && is_digit(c)) begin
                np = PH_INT;
            end
        end else if (form == FORM_DEC) begin
            if (ph == PH_BEGIN && is_sign(c)) begin
                np = PH_SIGN;
            end else if (ph inside {PH_BEGIN, PH_SIGN} && c == CH_DOT) begin
                np = PH_DOTNODIG;
            end else if (ph inside {PH_BEGIN, PH_SIGN, PH_INT} && is_digit(c)) begin
                np = PH_INT;
            end else if (ph == PH_INT && c == CH_DOT) begin
                np = PH_DOT;
            end else if (ph inside {PH_DOT, PH_DOTNODIG, PH_FRAC} && is_digit(c)) begin
                np = PH_FRAC;
            end
        end else begin
            if (ph == PH_BEGIN && is_sign(c)) begin
                np = PH_SIGN;
            end else if (ph inside {PH_BEGIN, PH_SIGN, PH_INT} && is_digit(c)) begin
                np = PH_INT;
            end else if (ph == PH_INT && c == CH_DOT) begin
                np = PH_DOT;
            end else if (ph inside {PH_DOT, PH_FRAC} && is_digit(c)) begin
                np = PH_FRAC;
            end else if (ph inside {PH_INT, PH_DOT, PH_FRAC} && is_exp(c)) begin
                np = PH_EXPE;
            end else if (ph == PH_EXPE && is_sign(c)) begin
                np = PH_EXPSIGN;
            end else if (ph inside {PH_EXPE, PH_EXPSIGN, PH_EXPDIG} && is_digit(c)) begin
                np = PH_EXPDIG;
            end
        end
        return np;
    endfunction

    function automatic logic numeric_accepts(input t_form form, input t_phase ph);
        logic ok;
        if (form == FORM_INT) begin
            ok = (ph == PH_INT);
        end else if (form == FORM_DEC) begin
            ok = ph inside {PH_INT, PH_DOT, PH_FRAC};
        end else begin
            ok = ph inside {PH_INT, PH_FRAC, PH_EXPDIG};
        end
        return ok;
    endfunction

endpackage

>>> rtl/xlfv_parser.sv
`timescale 1ns / 1ps
// per-string parse state and per-character checks for one literal
// depends on xlfv_pkg

module xlfv_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  xlfv_pkg::t_item  i_item,
    output xlfv_pkg::t_result o_result
);

    xlfv_pkg::t_phase                r_phase, n_phase;
    xlfv_pkg::t_form                 r_form, n_form;
    logic [2:0]                      r_pos, n_pos;
    logic [xlfv_pkg::NWORDS-1:0]     r_cand, n_cand;
    logic                            r_rej, n_rej;

    logic [xlfv_pkg::NWORDS-1:0]     w_ended;
    xlfv_pkg::t_phase                w_np;
    logic                            w_numeric;
    logic [5:0]                      w_bit;

    always_comb begin
        n_form  = r_form;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cand  = r_cand;
        n_rej   = r_rej;
        w_np    = xlfv_pkg::PH_IDLE;
        w_bit   = {~r_pos, 3'b000};
        if (r_phase == xlfv_pkg::PH_IDLE) begin
            n_form  = i_item.func;
            n_phase = xlfv_pkg::PH_BEGIN;
        end
        w_numeric = (n_form == xlfv_pkg::FORM_INT) || (n_form == xlfv_pkg::FORM_DEC) ||
                    (n_form == xlfv_pkg::FORM_DBL);
        if (i_item.has_char) begin
            for (int k = 0; k < xlfv_pkg::NWORDS; k++) begin
                n_cand[k] = r_cand[k] && (r_pos < xlfv_pkg::WORD_LEN[k]) &&
                            (xlfv_pkg::WORD_TEXT[k][w_bit +: 8] == i_item.char_byte);
            end
            if (r_pos != 3'd7) begin
                n_pos = r_pos + 3'd1;
            end
            if (w_numeric && !r_rej) begin
                w_np = xlfv_pkg::next_phase(n_form, n_phase, i_item.char_byte);
                if (w_np == xlfv_pkg::PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_phase = w_np;
                end
            end
        end
        for (int k = 0; k < xlfv_pkg::NWORDS; k++) begin
            w_ended[k] = n_cand[k] && (xlfv_pkg::WORD_LEN[k] == n_pos);
        end
    end

    always_comb begin
        o_result = '0;
        if (n_form == xlfv_pkg::FORM_BOOL) begin
            o_result.valid_res  = |(w_ended & xlfv_pkg::BOOL_WORDS);
            o_result.bool_value = |(w_ended & xlfv_pkg::TRUE_WORDS);
        end else if (n_form == xlfv_pkg::FORM_INT || n_form == xlfv_pkg::FORM_DEC) begin
            o_result.valid_res = !n_rej && xlfv_pkg::numeric_accepts(n_form, n_phase);
        end else if (n_form == xlfv_pkg::FORM_DBL) begin
            o_result.valid_res = (|(w_ended & xlfv_pkg::SPECIAL_WORDS)) ||
                                 (!n_rej && xlfv_pkg::numeric_accepts(n_form, n_phase));
        end else begin
            o_result.valid_res = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_phase <= xlfv_pkg::PH_IDLE;
            r_form  <= xlfv_pkg::FORM_BOOL;
            r_pos   <= '0;
            r_cand  <= xlfv_pkg::ALL_WORDS;
            r_rej   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_form  <= n_form;
            r_pos   <= n_pos;
            r_cand  <= n_cand;
            r_rej   <= n_rej;
        end
    end

endmodule

>>> rtl/xsd_lexical_form_validator_top.sv
`timescale 1ns / 1ps
// xsd lexical form validator top level: input register, parser, result register
// depends on xlfv_pkg and xlfv_parser
// result: registered in the result register once the final transaction leaves the input register
// throughput: one character per cycle, set by the combinational parse step; a final
// character waits while the result register is held by the downstream stall
// reset: synchronous, active low; clears both valid flags and the parse state

module xsd_lexical_form_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_char_byte,
    input  logic       i_has_char,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_valid_res,
    output logic       o_bool_value
);

    logic              r_in_valid;
    xlfv_pkg::t_item   r_in_item;
    logic              r_out_valid;
    xlfv_pkg::t_result r_out_res;

    xlfv_pkg::t_result w_res;
    logic              w_out_free;
    logic              w_fire;
    logic              w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fire     = r_in_valid && (!r_in_item.last || w_out_free);
    assign o_stall    = r_in_valid && !w_fire;
    assign w_accept   = i_valid && !o_stall;

    xlfv_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.func      <= i_func;
            r_in_item.char_byte <= i_char_byte;
            r_in_item.has_char  <= i_has_char;
            r_in_item.last      <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && r_in_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_res <= w_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_valid_res  = r_out_res.valid_res;
    assign o_bool_value = r_out_res.bool_value;

endmodule
